// File: rtl/lslr_pkg.sv
package lslr_pkg;

    localparam int LSLR_WEIGHT_COUNT = 1024;

    localparam int IDX_W     = 10;
    localparam int IDX_EXT_W = 17;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;
    localparam int CNT_W     = 32;

    // loss numerator after the fixed 2^17 scale is taken out
    localparam int NUM_W  = 47;
    localparam int STEP_W = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_FEATURE = 2'd1,
        ACT_CLOSE   = 2'd2,
        ACT_FINISH  = 2'd3
    } action_t;

    localparam logic KIND_RESIDUAL = 1'b0;
    localparam logic KIND_LOSS     = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_ROUND,
        S_SQUARE,
        S_LOSS,
        S_FNUM,
        S_DIVIDE,
        S_FEMIT
    } seq_state_t;

    typedef struct packed {
        logic mul_en;
        logic clear;
    } mac_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    function automatic logic signed [ACC_W-1:0] sat_add64(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W-1:0] s;
        s = a + b;
        if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1])
        begin
            s = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
        end
        return s;
    endfunction

endpackage

// File: rtl/least_squares_loss_residual.sv
// Least-squares loss engine for a linear model in signed Q16.16. Load words
// (action 0) write the weight memory; feature words (action 1) multiply the
// stored weight at their index with the value and accumulate the dot product;
// a close word (action 2) carries the label and returns the residual (kind 0),
// adds its square to the loss sum and counts the sample; a finish word
// (action 3) returns loss_sum / (2 * count) (kind 1) and clears sum and count.
// Indexes at or beyond WEIGHT_COUNT are ignored. Load and feature words are
// taken one per cycle, back to back, unless a close or finish word is in
// flight: the weight memory is read at the accept edge, the product is
// registered, then added to the dot product. A close word holds the input
// while the residual sequencer steps through subtract, round, square and loss
// add; a finish word, while the 47-step bit-serial divider runs. Results sit in
// an output register, so a stalled result does not block the preceding feature
// stream. Weights read back undefined until loaded; there is no clearing pass.
module least_squares_loss_residual
    import lslr_pkg::*;
#(
    parameter int WEIGHT_COUNT = LSLR_WEIGHT_COUNT
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [1:0]               action,
    input  logic [IDX_W-1:0]         index,
    input  logic signed [DATA_W-1:0] value,

    output logic                     result_valid,
    input  logic                     result_stall,
    output logic                     kind,
    output logic signed [DATA_W-1:0] result
);

    // accept stage
    logic                     accept;
    action_t                  item_action;
    logic                     mem_hit;
    logic signed [DATA_W-1:0] weight;

    logic                     s1_valid_reg;
    action_t                  s1_action_reg;
    logic signed [DATA_W-1:0] s1_value_reg;
    logic                     s1_hit_reg;
    logic                     s1_ends_sample;

    // sequencer
    seq_state_t               state_reg;
    seq_state_t               state_next;
    mac_ctl_t                 mac_ctl;
    logic signed [ACC_W-1:0]  dot_sum;

    logic signed [DATA_W-1:0] label_reg;
    logic signed [ACC_W-1:0]  diff_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic signed [ACC_W-1:0]  sq_reg;
    logic signed [ACC_W-1:0]  loss_sum_reg;
    logic [CNT_W-1:0]         sample_count_reg;
    logic                     fin_zero_reg;

    logic signed [ACC_W-1:0]  label_q32;
    logic signed [ACC_W-1:0]  diff_next;
    logic signed [ACC_W-1:0]  round_sum;
    logic signed [47:0]       round_shift;
    logic signed [DATA_W-1:0] res_next;
    logic signed [ACC_W-1:0]  sq_next;

    logic [ACC_W-1:0]         loss_pos;
    logic [ACC_W-1:0]         num_full;
    div_stat_t                div_stat;
    logic [NUM_W-1:0]         quo;
    logic signed [DATA_W-1:0] loss_q16;

    logic                     out_free;
    logic                     take_label;
    logic                     do_diff;
    logic                     do_round;
    logic                     do_square;
    logic                     do_commit;
    logic                     do_fnum;
    logic                     div_start;
    logic                     emit_loss;

    logic                     out_valid_reg;
    logic                     kind_reg;
    logic signed [DATA_W-1:0] result_reg;

    assign item_action    = action_t'(action);
    assign s1_ends_sample = s1_valid_reg &&
                            (s1_action_reg == ACT_CLOSE || s1_action_reg == ACT_FINISH);

    // hold input while a close or finish word is in flight
    assign item_stall = (state_reg != S_IDLE) || s1_ends_sample;
    assign accept     = item_valid && !item_stall;

    lslr_wmem #(
        .WEIGHT_COUNT (WEIGHT_COUNT)
    ) u_wmem (
        .clk     (clk),
        .wr_en   (accept && item_action == ACT_LOAD),
        .rd_en   (accept && item_action == ACT_FEATURE),
        .idx     (index),
        .wr_data (value),
        .hit     (mem_hit),
        .rd_data (weight)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg <= item_action;
            s1_value_reg  <= value;
            s1_hit_reg    <= mem_hit;
        end
    end

    // product and dot product accumulate; cleared once the residual is taken
    assign mac_ctl.mul_en = s1_valid_reg && s1_action_reg == ACT_FEATURE && s1_hit_reg;
    assign mac_ctl.clear  = do_diff;

    lslr_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .weight  (weight),
        .feature (s1_value_reg),
        .dot_sum (dot_sum)
    );

    // residual datapath: subtract label, round half up to q16.16, square
    assign label_q32   = {{(ACC_W-DATA_W-16){label_reg[DATA_W-1]}}, label_reg, 16'b0};
    assign diff_next   = sat_add64(dot_sum, -label_q32);
    assign round_sum   = sat_add64(diff_reg, ACC_W'(32768));
    assign round_shift = round_sum[ACC_W-1:16];

    always_comb
    begin
        if (round_shift[47:DATA_W-1] == {(48-DATA_W+1){round_shift[47]}})
        begin
            res_next = round_shift[DATA_W-1:0];
        end
        else if (round_shift[47])
        begin
            res_next = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            res_next = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign sq_next = res_reg * res_reg;

    // mean loss: (s + count*2^16) >> 17 then divide by count
    assign loss_pos = loss_sum_reg[ACC_W-1] ? '0 : ACC_W'(loss_sum_reg);
    assign num_full = loss_pos + {16'b0, sample_count_reg, 16'b0};

    lslr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_full[ACC_W-1:17]),
        .den   (sample_count_reg),
        .stat  (div_stat),
        .quo   (quo)
    );

    assign loss_q16 = (|quo[NUM_W-1:DATA_W-1]) ? {1'b0, {(DATA_W-1){1'b1}}}
                                               : {1'b0, quo[DATA_W-2:0]};

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        take_label = 1'b0;
        do_diff    = 1'b0;
        do_round   = 1'b0;
        do_square  = 1'b0;
        do_commit  = 1'b0;
        do_fnum    = 1'b0;
        div_start  = 1'b0;
        emit_loss  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s1_valid_reg && s1_action_reg == ACT_CLOSE)
                begin
                    take_label = 1'b1;
                    state_next = S_DIFF;
                end
                else if (s1_valid_reg && s1_action_reg == ACT_FINISH)
                begin
                    state_next = S_FNUM;
                end
            end
            S_DIFF:
            begin
                do_diff    = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                do_round   = 1'b1;
                state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                do_square  = 1'b1;
                state_next = S_LOSS;
            end
            S_LOSS:
            begin
                if (out_free)
                begin
                    do_commit  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FNUM:
            begin
                do_fnum    = 1'b1;
                div_start  = sample_count_reg != '0;
                state_next = (sample_count_reg != '0) ? S_DIVIDE : S_FEMIT;
            end
            S_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = S_FEMIT;
                end
            end
            S_FEMIT:
            begin
                if (out_free)
                begin
                    emit_loss  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            loss_sum_reg     <= '0;
            sample_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (do_commit)
            begin
                loss_sum_reg <= sat_add64(loss_sum_reg, sq_reg);
                if (sample_count_reg != '1)
                begin
                    sample_count_reg <= sample_count_reg + 1'b1;
                end
            end
            else if (do_fnum)
            begin
                loss_sum_reg     <= '0;
                sample_count_reg <= '0;
            end

            if (do_commit || emit_loss)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_label)
        begin
            label_reg <= s1_value_reg;
        end
        if (do_diff)
        begin
            diff_reg <= diff_next;
        end
        if (do_round)
        begin
            res_reg <= res_next;
        end
        if (do_square)
        begin
            sq_reg <= sq_next;
        end
        if (do_fnum)
        begin
            fin_zero_reg <= sample_count_reg == '0;
        end
        if (do_commit)
        begin
            kind_reg   <= KIND_RESIDUAL;
            result_reg <= res_reg;
        end
        else if (emit_loss)
        begin
            kind_reg   <= KIND_LOSS;
            result_reg <= fin_zero_reg ? '0 : loss_q16;
        end
    end

    assign result_valid = out_valid_reg;
    assign kind         = kind_reg;
    assign result       = result_reg;

endmodule

// File: rtl/lslr_wmem.sv
module lslr_wmem
    import lslr_pkg::*;
#(
    parameter int WEIGHT_COUNT = LSLR_WEIGHT_COUNT
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [IDX_W-1:0]         idx,
    input  logic signed [DATA_W-1:0] wr_data,
    output logic                     hit,
    output logic signed [DATA_W-1:0] rd_data
);

    localparam int AW = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;

    logic signed [DATA_W-1:0] mem [WEIGHT_COUNT];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [IDX_EXT_W-1:0]     idx_ext;
    logic [AW-1:0]            addr;

    assign idx_ext = IDX_EXT_W'(idx);
    assign addr    = idx_ext[AW-1:0];
    assign hit     = idx_ext < IDX_EXT_W'(WEIGHT_COUNT);

    // one port: write for loads, read for features, never both in a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en && hit)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/lslr_mac.sv
module lslr_mac
    import lslr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctl_t                 ctl,
    input  logic signed [DATA_W-1:0] weight,
    input  logic signed [DATA_W-1:0] feature,
    output logic signed [ACC_W-1:0]  dot_sum
);

    logic                    prod_valid_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] prod_next;
    logic signed [ACC_W-1:0] dot_sum_reg;
    logic signed [ACC_W-1:0] dot_sum_next;

    assign prod_next = weight * feature;

    always_comb
    begin
        dot_sum_next = dot_sum_reg;
        if (ctl.clear)
        begin
            dot_sum_next = '0;
        end
        else if (prod_valid_reg)
        begin
            dot_sum_next = sat_add64(dot_sum_reg, prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            dot_sum_reg    <= '0;
        end
        else
        begin
            prod_valid_reg <= ctl.mul_en;
            dot_sum_reg    <= dot_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign dot_sum = dot_sum_reg;

endmodule

// File: rtl/lslr_div.sv
module lslr_div
    import lslr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NUM_W-1:0]   num,
    input  logic [CNT_W-1:0]   den,
    output div_stat_t          stat,
    output logic [NUM_W-1:0]   quo
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  den_reg;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_sub;
    logic              ge;

    // restoring division, one quotient bit per cycle
    assign trial     = {rem_reg, quo_reg[NUM_W-1]};
    assign ge        = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

// File: rtl/lslr_chk.sv
module lslr_chk
    import lslr_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     item_valid,
    input logic                     item_stall,
    input logic [1:0]               action,
    input logic                     result_valid,
    input logic                     result_stall,
    input logic                     kind,
    input logic signed [DATA_W-1:0] result
);

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(kind) && $stable(result))
        else $error("stalled result word changed");

    // close and finish words block the input the next cycle
    a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall &&
            (action == ACT_CLOSE || action == ACT_FINISH) |=> item_stall)
        else $error("input not held after close or finish");

    // a new result only comes out of a busy sequencer
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result word without close or finish");

    // mean loss is never negative
    a_loss_sign: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_LOSS |-> !result[DATA_W-1])
        else $error("negative mean loss");

endmodule

bind least_squares_loss_residual lslr_chk u_chk (.*);

// File: verif/tb.sv
module tb;
    import lslr_pkg::*;

    localparam int     RANDOM_WORDS = 1650;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     HOLD_AFTER   = 400;
    localparam int     TAIL_CYCLES  = 64;
    localparam longint Q16_MAX      = 64'sd2147483647;
    localparam longint Q16_MIN      = -64'sd2147483648;
    localparam longint Q32_MAX      = 64'sh7fff_ffff_ffff_ffff;
    localparam longint Q32_MIN      = 64'sh8000_0000_0000_0000;

    // one input word as queued for the driver; drain makes the driver wait
    // until every outstanding result has come back before offering it
    typedef struct {
        action_t                  act;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] val;
        bit                       drain;
    } word_t;

    typedef struct {
        logic                     kind;
        logic signed [DATA_W-1:0] val;
    } outcome_t;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     item_valid   = 1'b0;
    logic                     item_stall;
    logic [1:0]               action       = ACT_LOAD;
    logic [IDX_W-1:0]         index        = '0;
    logic signed [DATA_W-1:0] value        = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic                     kind;
    logic signed [DATA_W-1:0] result;

    least_squares_loss_residual dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .index        (index),
        .value        (value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .result       (result)
    );

    always #10 clk = ~clk;

    // words waiting to be driven, and results owed by the block, oldest first
    word_t    word_q[$];
    outcome_t due_q[$];

    // generator-side record of which weights have been written, so that a
    // feature word never reads an unwritten weight
    bit loaded[LSLR_WEIGHT_COUNT];
    int loaded_list[$];

    // shadow of the engine state
    logic signed [DATA_W-1:0] shadow_weight[LSLR_WEIGHT_COUNT];
    longint                   dot_acc   = 0;
    longint                   loss_acc  = 0;
    int unsigned              sample_n  = 0;

    int     errors      = 0;
    int     cycle_n     = 0;
    int     words_taken = 0;
    logic   in_fire     = 1'b0;
    logic   hold_off    = 1'b0;

    // driver and receiver pacing
    word_t  cur;
    int     gap_left    = 0;
    int     burst_left  = 1;
    int     stall_mode  = 0;
    int     mode_left   = 0;
    logic   pat         = 1'b0;
    logic   toggle      = 1'b0;

    task automatic report_mismatch(string what, logic signed [DATA_W-1:0] got,
                                   logic signed [DATA_W-1:0] want);
        $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_n);
        errors++;
    endtask

    // 64-bit add clamped to the signed range, done in 65 bits
    function automatic longint clamp_add64(longint a, longint b);
        logic signed [64:0] w;
        w = {a[63], a} + {b[63], b};
        if (w[64] != w[63])
        begin
            return w[64] ? Q32_MIN : Q32_MAX;
        end
        return w[63:0];
    endfunction

    // advance the shadow state by one accepted word and queue what it owes
    task automatic step_loss_engine(action_t a, logic [IDX_W-1:0] i,
                                    logic signed [DATA_W-1:0] v);
        longint                   diff;
        longint                   rounded;
        longint                   sq;
        longint unsigned          dvs;
        longint unsigned          num;
        longint unsigned          quo;
        logic signed [DATA_W-1:0] res;
        case (a)
            ACT_LOAD:
            begin
                shadow_weight[i] = v;
            end
            ACT_FEATURE:
            begin
                dot_acc = clamp_add64(dot_acc, longint'(shadow_weight[i]) * longint'(v));
            end
            ACT_CLOSE:
            begin
                // residual in Q32.32, then round half up into Q16.16
                diff    = clamp_add64(dot_acc, -(longint'(v) <<< 16));
                rounded = clamp_add64(diff, 64'sd32768) >>> 16;
                if (rounded > Q16_MAX)
                    res = 32'sh7fff_ffff;
                else if (rounded < Q16_MIN)
                    res = 32'sh8000_0000;
                else
                    res = rounded[DATA_W-1:0];
                sq       = longint'(res) * longint'(res);
                dot_acc  = 0;
                loss_acc = clamp_add64(loss_acc, sq);
                if (sample_n != 32'hffff_ffff)
                    sample_n++;
                due_q.push_back('{KIND_RESIDUAL, res});
            end
            default:
            begin
                // mean loss: sum / (2 * count), with the Q32.32 -> Q16.16 step
                res = '0;
                if (sample_n != 0)
                begin
                    dvs = longint'(sample_n) * 64'd131072;
                    num = (loss_acc > 0) ? loss_acc : 0;
                    quo = (num + dvs / 2) / dvs;
                    if (quo > 64'd2147483647)
                        quo = 64'd2147483647;
                    res = quo[DATA_W-1:0];
                end
                loss_acc = 0;
                sample_n = 0;
                due_q.push_back('{KIND_LOSS, res});
            end
        endcase
    endtask

    task automatic add_word(action_t a, int i, logic signed [DATA_W-1:0] v);
        word_t w;
        w.act   = a;
        w.idx   = i[IDX_W-1:0];
        w.val   = v;
        w.drain = 1'b0;
        if (a == ACT_LOAD && !loaded[i])
        begin
            loaded[i] = 1'b1;
            loaded_list.push_back(i);
        end
        word_q.push_back(w);
    endtask

    // mostly moderate magnitudes so that sums stay in range, now and then a
    // full-range word to hit the saturating paths
    function automatic logic signed [DATA_W-1:0] rand_q16(int mag);
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return $urandom_range(0, (1 << (mag + 1)) - 1) - (1 << mag);
    endfunction

    task automatic add_features(int n);
        int start;
        int j;
        int k;
        if ($urandom_range(0, 1) == 0)
        begin
            // sparse: any written index, any order
            for (k = 0; k < n; k++)
                add_word(ACT_FEATURE, loaded_list[$urandom_range(0, loaded_list.size() - 1)],
                         rand_q16(18));
        end
        else
        begin
            // dense: walk upward through written indexes
            start = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            k = 0;
            for (j = start; j < LSLR_WEIGHT_COUNT && k < n && loaded[j]; j++)
            begin
                add_word(ACT_FEATURE, j, rand_q16(18));
                k++;
            end
        end
    endtask

    task automatic add_loads();
        int b;
        int n;
        int k;
        if ($urandom_range(0, 1) == 0)
        begin
            b = $urandom_range(0, LSLR_WEIGHT_COUNT - 17);
            n = $urandom_range(4, 16);
            for (k = 0; k < n; k++)
                add_word(ACT_LOAD, b + k, rand_q16(18));
        end
        else
        begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++)
                add_word(ACT_LOAD, $urandom_range(0, LSLR_WEIGHT_COUNT - 1), rand_q16(18));
        end
    endtask

    // input side: a new word goes out at the falling edge once the previous
    // one was taken; bursts of random length with random gaps between them
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!item_valid || in_fire)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (word_q.size() == 0 || (word_q[0].drain && due_q.size() != 0))
            begin
                // nothing left, or a drain point waiting for the results to come home
                item_valid <= 1'b0;
            end
            else
            begin
                cur = word_q.pop_front();
                item_valid <= 1'b1;
                action     <= cur.act;
                index      <= cur.idx;
                value      <= cur.val;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left--;
                end
            end
        end
    end

    // output side: stall pattern changes mode every so often; the long
    // hold-off is laid on top of it
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end
        else
        begin
            mode_left--;
        end
        toggle = ~toggle;
        case (stall_mode)
            0:       pat = 1'b0;
            1:       pat = ($urandom_range(0, 3) == 0);
            2:       pat = ($urandom_range(0, 3) != 0);
            default: pat = toggle;
        endcase
        result_stall <= hold_off | pat;
    end

    // receiver holds off for a long stretch while words keep coming, so the
    // output register fills and the block has to stall its input
    initial
    begin
        while (words_taken < HOLD_AFTER)
            @(posedge clk);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    // check results first, then advance the shadow on the accepted input word,
    // all at the rising edge so that ordering within the step does not matter
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (due_q.size() == 0)
                begin
                    report_mismatch("unexpected result", result, '0);
                end
                else
                begin
                    if (kind !== due_q[0].kind)
                        report_mismatch("kind", {31'd0, kind}, {31'd0, due_q[0].kind});
                    if (result !== due_q[0].val)
                        report_mismatch("result", result, due_q[0].val);
                    void'(due_q.pop_front());
                end
            end
            if (item_valid && !item_stall)
            begin
                step_loss_engine(action_t'(action), index, value);
                words_taken++;
            end
        end
        in_fire <= rst_n && item_valid && !item_stall;
    end

    always @(posedge clk)
    begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        int base_n;
        int r;
        int k;

        // ---- directed words ----
        // finish with no samples yet
        add_word(ACT_FINISH, 0, '0);
        // extreme weights, plus 0.0 and 1.0
        add_word(ACT_LOAD, 0, 32'sh7fff_ffff);
        add_word(ACT_LOAD, 1023, 32'sh8000_0000);
        add_word(ACT_LOAD, 1, 32'sh0000_0000);
        add_word(ACT_LOAD, 512, 32'sh0001_0000);
        // dot product driven past the top of 64 bits, label at its minimum:
        // residual clamps high
        add_word(ACT_FEATURE, 1, 32'sh7fff_ffff);
        add_word(ACT_FEATURE, 1023, 32'sh8000_0000);
        add_word(ACT_FEATURE, 1023, 32'sh8000_0000);
        add_word(ACT_FEATURE, 1023, 32'sh8000_0000);
        add_word(ACT_CLOSE, 1023, 32'sh8000_0000);
        // empty sample, label at its maximum
        add_word(ACT_CLOSE, 0, 32'sh7fff_ffff);
        // dot product driven past the bottom: residual clamps low
        add_word(ACT_FEATURE, 0, 32'sh8000_0000);
        add_word(ACT_FEATURE, 0, 32'sh8000_0000);
        add_word(ACT_FEATURE, 0, 32'sh8000_0000);
        add_word(ACT_CLOSE, 0, 32'sh7fff_ffff);
        // finish in the middle of a sample leaves the open dot product alone
        add_word(ACT_FEATURE, 512, 32'sh0003_0000);
        add_word(ACT_FINISH, 1023, 32'sh7fff_ffff);
        add_word(ACT_CLOSE, 512, 32'sh0001_0000);
        // loss sum at its clamp, mean clamped
        add_word(ACT_CLOSE, 0, 32'sh8000_0000);
        add_word(ACT_CLOSE, 0, 32'sh8000_0000);
        add_word(ACT_FINISH, 0, '0);
        base_n = word_q.size();

        // ---- random words ----
        for (k = 0; k < 4; k++)
            add_loads();
        while (word_q.size() < base_n + RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                add_loads();
            end
            else if (r < 14)
            begin
                add_word(ACT_FINISH, $urandom_range(0, LSLR_WEIGHT_COUNT - 1), $urandom);
            end
            else if (r < 18)
            begin
                // broken sequences: finish or loads mid-sample, bare closes
                add_features($urandom_range(0, 4));
                if ($urandom_range(0, 1) == 0)
                    add_word(ACT_FINISH, $urandom_range(0, LSLR_WEIGHT_COUNT - 1), $urandom);
                else
                    add_loads();
                add_features($urandom_range(0, 4));
                add_word(ACT_CLOSE, $urandom_range(0, LSLR_WEIGHT_COUNT - 1), $urandom);
            end
            else
            begin
                add_features($urandom_range(1, 12));
                add_word(ACT_CLOSE, $urandom_range(0, LSLR_WEIGHT_COUNT - 1), rand_q16(20));
            end
        end
        // sender pauses here until every owed result is back
        word_q[base_n + RANDOM_WORDS / 2].drain = 1'b1;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (word_q.size() != 0 || item_valid)
            @(posedge clk);
        while (due_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
